// ----- rtl/scba_pkg.sv -----
// ----------------------------------------------------------------------------
// Size-class allocator package
// Shared constants, types and class-size functions.
// ----------------------------------------------------------------------------
package scba_pkg;

  localparam int CLASS_COUNT  = 56;
  localparam int SEGMENT_BITS = 34;
  localparam longint CHUNK_BYTES = 2097152;
  localparam int FREE_DEPTH   = 64;

  localparam int LIVE_CLASSES = (CLASS_COUNT < 56) ? CLASS_COUNT : 56;
  localparam int CA_W   = $clog2(CLASS_COUNT);
  localparam int CLS_W  = 6;
  localparam int ADDR_W = 47;
  localparam int SIZE_W = 19;
  localparam int CUR_W  = SEGMENT_BITS + 1;
  localparam int MAP_W  = SEGMENT_BITS - $clog2(CHUNK_BYTES) + 1;
  localparam int CNT_W  = $clog2(FREE_DEPTH + 1);
  localparam int SA_W   = $clog2(CLASS_COUNT * FREE_DEPTH);
  localparam int WIDE_W = SEGMENT_BITS + 6;

  localparam logic [47:0] REGION_START = 48'h2000 << 32;
  localparam logic [47:0] REGION_END   =
    REGION_START + (48'(LIVE_CLASSES) << SEGMENT_BITS);
  localparam logic [47:0] SMALL_MAX    = 48'd262144;

  localparam logic FN_ALLOC   = 1'b0;
  localparam logic FN_RELEASE = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_LARGE   = 2'd1;
  localparam logic [1:0] ST_EXHAUST = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  typedef struct packed {
    logic [CUR_W-1:0] cursor;
    logic [MAP_W-1:0] mapped;
    logic [CNT_W-1:0] count;
  } class_entry_t;

  typedef struct packed {
    logic             done;
    logic [CLS_W-1:0] cls;
  } walk_res_t;

  function automatic logic [SIZE_W-1:0] size_of_class(input logic [CLS_W-1:0] c);
    logic [CLS_W-1:0]  d;
    logic [SIZE_W-1:0] base;
    if (c < CLS_W'(16)) begin
      size_of_class = SIZE_W'({c, 4'b0}) + SIZE_W'(16);
    end else begin
      d = c - CLS_W'(16);
      base = SIZE_W'(1) << (8 + int'(d[CLS_W-1:2]));
      size_of_class = base + (base >> 2) * (SIZE_W'(d[1:0]) + SIZE_W'(1));
    end
  endfunction

  function automatic logic [CLS_W-1:0] class_of_size(input logic [SIZE_W-1:0] n);
    logic [SIZE_W-1:0] m;
    logic [SIZE_W-1:0] sh;
    int e;
    e = 0;
    m = n - SIZE_W'(1);
    if (n <= SIZE_W'(256)) begin
      class_of_size = (n == '0) ? '0 : CLS_W'(((n + SIZE_W'(15)) >> 4) - SIZE_W'(1));
    end else begin
      for (int i = 0; i < SIZE_W; i++) begin
        if (m[i]) e = i;
      end
      sh = m >> (e - 2);
      class_of_size = CLS_W'(16 + (e - 8) * 4) + CLS_W'(sh[1:0]);
    end
  endfunction

endpackage

// ----- rtl/scba_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module scba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/scba_align_walk.sv -----
// ----------------------------------------------------------------------------
// Alignment class walk
// Steps classes upward until the alignment divides the class size or the live
// classes run out; one remainder bit per cycle.
// ----------------------------------------------------------------------------
module scba_align_walk (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [scba_pkg::CLS_W-1:0]         cls_init,
  input  logic [scba_pkg::SIZE_W-1:0]        align,
  output scba_pkg::walk_res_t                res
);

  logic                          busy;
  logic [scba_pkg::CLS_W-1:0]    cls;
  logic [scba_pkg::SIZE_W-1:0]   size;
  logic [scba_pkg::SIZE_W-1:0]   rem;
  logic [4:0]                    bitn;
  logic                          done;
  logic [scba_pkg::SIZE_W:0]     rem_sh;
  logic [scba_pkg::SIZE_W:0]     rem_next;
  logic [scba_pkg::CLS_W-1:0]    cls_next;

  always_comb begin
    rem_sh   = {rem, size[bitn]};
    rem_next = (rem_sh >= {1'b0, align}) ? rem_sh - {1'b0, align} : rem_sh;
    cls_next = cls + scba_pkg::CLS_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cls  <= cls_init;
        size <= scba_pkg::size_of_class(cls_init);
        rem  <= '0;
        bitn <= 5'(scba_pkg::SIZE_W - 1);
        if (cls_init >= scba_pkg::CLS_W'(scba_pkg::LIVE_CLASSES)) begin
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
        end
      end else if (busy) begin
        if (bitn == '0) begin
          if (rem_next == '0) begin
            busy <= 1'b0;
            done <= 1'b1;
          end else begin
            cls  <= cls_next;
            size <= scba_pkg::size_of_class(cls_next);
            rem  <= '0;
            bitn <= 5'(scba_pkg::SIZE_W - 1);
            if (cls_next >= scba_pkg::CLS_W'(scba_pkg::LIVE_CLASSES)) begin
              busy <= 1'b0;
              done <= 1'b1;
            end
          end
        end else begin
          rem  <= rem_next[scba_pkg::SIZE_W-1:0];
          bitn <= bitn - 5'd1;
        end
      end
    end
  end

  assign res.done = done;
  assign res.cls  = cls;

endmodule

// ----- rtl/size_class_block_allocator_top.sv -----
// ----------------------------------------------------------------------------
// Size-class block allocator
// Flow: an accepted word goes through S_CLASS, S_READ and S_EXEC to S_OUT; a
// free-stack pop adds S_POP, and the large path goes from S_CLASS straight to
// S_OUT. An alignment above 16 bytes adds S_WALK, where the bit-serial
// remainder unit tests one class after another. One word is in flight at a
// time, so a new word is taken only once the last result has been registered.
// Reset clears the class-table valid flags at once; no clearing pass.
// ----------------------------------------------------------------------------
module size_class_block_allocator_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               func,
  input  logic [47:0]                        request_size,
  input  logic [20:0]                        alignment,
  input  logic [46:0]                        block_address,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [46:0]                        address,
  output logic [5:0]                         size_class,
  output logic [18:0]                        block_size,
  output logic [1:0]                         status,
  output logic                               from_free_list,
  output logic                               chunk_mapped
);

  typedef enum logic [2:0] {
    S_IDLE, S_CLASS, S_WALK, S_READ, S_EXEC, S_POP, S_OUT
  } state_t;

  state_t                          state;
  logic                            func_q;
  logic [47:0]                     req_q;
  logic [20:0]                     align_q;
  logic [46:0]                     baddr_q;
  logic [scba_pkg::CLS_W-1:0]      cls;
  logic [1:0]                      r_status;
  logic [46:0]                     r_addr;
  logic                            r_ffl;
  logic                            r_chunk;
  logic [scba_pkg::CLASS_COUNT-1:0] cls_valid;

  logic [20:0]                     align_eff;
  logic                            is_large;
  logic [scba_pkg::SIZE_W-1:0]     n_eff;
  logic [scba_pkg::CLS_W-1:0]      cls0;
  logic                            rel_in;
  logic [47:0]                     rel_off;
  logic [scba_pkg::CA_W-1:0]       cls_idx;
  logic [scba_pkg::SIZE_W-1:0]     size;
  logic [46:0]                     seg_base;

  logic                            walk_start;
  scba_pkg::walk_res_t             walk_res;

  logic                            class_we;
  scba_pkg::class_entry_t          class_wdata;
  logic [$bits(scba_pkg::class_entry_t)-1:0] class_rdata;
  scba_pkg::class_entry_t          ent;

  logic                            store_we;
  logic [scba_pkg::SA_W-1:0]       store_waddr;
  logic [scba_pkg::SA_W-1:0]       store_raddr;
  logic [scba_pkg::SEGMENT_BITS-1:0] store_rdata;
  logic [scba_pkg::SA_W-1:0]       store_row;

  logic [scba_pkg::WIDE_W-1:0]     bump_sum;
  logic [scba_pkg::WIDE_W-1:0]     bump_top;
  logic                            need_chunk;
  logic                            exhausted;

  always_comb begin
    align_eff = (align_q <= 21'd16) ? 21'd16 : align_q;
    is_large  = (req_q > scba_pkg::SMALL_MAX) ||
                ({27'd0, align_eff} > scba_pkg::SMALL_MAX);
    n_eff     = (req_q[scba_pkg::SIZE_W-1:0] < align_eff[scba_pkg::SIZE_W-1:0]) ?
                align_eff[scba_pkg::SIZE_W-1:0] : req_q[scba_pkg::SIZE_W-1:0];
    cls0      = scba_pkg::class_of_size(n_eff);
    rel_in    = ({1'b0, baddr_q} >= scba_pkg::REGION_START) &&
                ({1'b0, baddr_q} <  scba_pkg::REGION_END);
    rel_off   = {1'b0, baddr_q} - scba_pkg::REGION_START;
    walk_start = (state == S_CLASS) && (func_q == scba_pkg::FN_ALLOC) && !is_large &&
                 (align_eff != 21'd16);

    cls_idx   = cls[scba_pkg::CA_W-1:0];
    size      = scba_pkg::size_of_class(cls);
    seg_base  = 47'(scba_pkg::REGION_START) + (47'(cls) << scba_pkg::SEGMENT_BITS);
    ent       = cls_valid[cls_idx] ? scba_pkg::class_entry_t'(class_rdata) : '0;

    store_row   = scba_pkg::SA_W'(cls) * scba_pkg::SA_W'(scba_pkg::FREE_DEPTH);
    store_waddr = store_row + scba_pkg::SA_W'(ent.count);
    store_raddr = store_row + scba_pkg::SA_W'(ent.count - scba_pkg::CNT_W'(1));

    bump_sum   = scba_pkg::WIDE_W'(ent.cursor) + scba_pkg::WIDE_W'(size);
    bump_top   = scba_pkg::WIDE_W'(ent.mapped) * scba_pkg::WIDE_W'(scba_pkg::CHUNK_BYTES);
    need_chunk = bump_sum > bump_top;
    exhausted  = (bump_top + scba_pkg::WIDE_W'(scba_pkg::CHUNK_BYTES)) >
                 (scba_pkg::WIDE_W'(1) << scba_pkg::SEGMENT_BITS);

    class_we    = 1'b0;
    class_wdata = ent;
    store_we    = 1'b0;
    if (state == S_EXEC) begin
      if (func_q == scba_pkg::FN_RELEASE) begin
        if (ent.count < scba_pkg::CNT_W'(scba_pkg::FREE_DEPTH)) begin
          store_we          = 1'b1;
          class_we          = 1'b1;
          class_wdata.count = ent.count + scba_pkg::CNT_W'(1);
        end
      end else if (ent.count != '0) begin
        class_we          = 1'b1;
        class_wdata.count = ent.count - scba_pkg::CNT_W'(1);
      end else if (!(need_chunk && exhausted)) begin
        class_we           = 1'b1;
        class_wdata.cursor = bump_sum[scba_pkg::CUR_W-1:0];
        if (need_chunk) class_wdata.mapped = ent.mapped + scba_pkg::MAP_W'(1);
      end
    end
  end

  scba_align_walk u_walk (
    .clk      (clk),
    .rst      (rst),
    .start    (walk_start),
    .cls_init (cls0),
    .align    (align_eff[scba_pkg::SIZE_W-1:0]),
    .res      (walk_res)
  );

  scba_ram #(
    .WIDTH ($bits(scba_pkg::class_entry_t)),
    .DEPTH (scba_pkg::CLASS_COUNT)
  ) u_class_ram (
    .clk   (clk),
    .we    (class_we),
    .waddr (cls_idx),
    .wdata (class_wdata),
    .raddr (cls_idx),
    .rdata (class_rdata)
  );

  scba_ram #(
    .WIDTH (scba_pkg::SEGMENT_BITS),
    .DEPTH (scba_pkg::CLASS_COUNT * scba_pkg::FREE_DEPTH)
  ) u_store_ram (
    .clk   (clk),
    .we    (store_we),
    .waddr (store_waddr),
    .wdata (rel_off[scba_pkg::SEGMENT_BITS-1:0]),
    .raddr (store_raddr),
    .rdata (store_rdata)
  );

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      cls_valid <= '0;
    end else begin
      if ((state == S_OUT) && (!out_valid || !out_stall)) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      if (class_we) cls_valid[cls_idx] <= 1'b1;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            func_q  <= func;
            req_q   <= request_size;
            align_q <= alignment;
            baddr_q <= block_address;
            state   <= S_CLASS;
          end
        end
        S_CLASS: begin
          r_addr   <= '0;
          r_ffl    <= 1'b0;
          r_chunk  <= 1'b0;
          if (func_q == scba_pkg::FN_RELEASE) begin
            cls <= scba_pkg::CLS_W'(rel_off >> scba_pkg::SEGMENT_BITS);
            if (rel_in) begin
              r_status <= scba_pkg::ST_OK;
              state    <= S_READ;
            end else begin
              r_status <= scba_pkg::ST_LARGE;
              state    <= S_OUT;
            end
          end else if (is_large) begin
            r_status <= scba_pkg::ST_LARGE;
            state    <= S_OUT;
          end else if (walk_start) begin
            r_status <= scba_pkg::ST_OK;
            state    <= S_WALK;
          end else begin
            cls <= cls0;
            if (cls0 >= scba_pkg::CLS_W'(scba_pkg::LIVE_CLASSES)) begin
              r_status <= scba_pkg::ST_LARGE;
              state    <= S_OUT;
            end else begin
              r_status <= scba_pkg::ST_OK;
              state    <= S_READ;
            end
          end
        end
        S_WALK: begin
          if (walk_res.done) begin
            cls <= walk_res.cls;
            if (walk_res.cls >= scba_pkg::CLS_W'(scba_pkg::LIVE_CLASSES)) begin
              r_status <= scba_pkg::ST_LARGE;
              state    <= S_OUT;
            end else begin
              state <= S_READ;
            end
          end
        end
        S_READ: state <= S_EXEC;
        S_EXEC: begin
          if (func_q == scba_pkg::FN_RELEASE) begin
            state <= S_OUT;
            if (!store_we) r_status <= scba_pkg::ST_FULL;
          end else if (ent.count != '0) begin
            state <= S_POP;
          end else if (need_chunk && exhausted) begin
            state    <= S_OUT;
            r_status <= scba_pkg::ST_EXHAUST;
          end else begin
            state   <= S_OUT;
            r_chunk <= need_chunk;
            r_addr  <= seg_base + 47'(ent.cursor);
          end
        end
        S_POP: begin
          r_ffl  <= 1'b1;
          r_addr <= seg_base + 47'(store_rdata);
          state  <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            address        <= r_addr;
            status         <= r_status;
            from_free_list <= r_ffl;
            chunk_mapped   <= r_chunk;
            size_class     <= (r_status == scba_pkg::ST_LARGE) ? '0 : cls;
            block_size     <= (r_status == scba_pkg::ST_LARGE) ? '0 : size;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_fail_no_addr: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != scba_pkg::ST_OK) |-> address == '0)
    else $error("address set on failed word");
  a_reuse_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && from_free_list |-> !chunk_mapped && (status == scba_pkg::ST_OK))
    else $error("reused block with chunk map or error");
  a_large_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == scba_pkg::ST_LARGE) |-> (size_class == '0) && (block_size == '0))
    else $error("large path word carries class");
  a_walk_alloc: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |-> (func_q == scba_pkg::FN_ALLOC))
    else $error("class walk on release");

endmodule

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// Size-class block allocator testbench
// Drives allocate and release words through a table of directed cases and then
// a random mix of requests; each result comes from a model of the class tables
// and free stacks or a typed row, and is checked field by field, in order.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import scba_pkg::*;

  localparam int NDIR = 16;
  localparam int NRAND = 850;
  localparam int WATCHDOG = 20000;
  localparam longint unsigned SEG_MASK = (64'd1 << SEGMENT_BITS) - 1;

  typedef struct {
    logic [46:0] addr;
    logic [5:0]  cls;
    logic [18:0] bsize;
    logic [1:0]  st;
    logic        reused;
    logic        mapped;
  } alloc_word_t;

  typedef struct {
    logic        f;
    logic [47:0] sz;
    logic [20:0] al;
    logic [46:0] ad;
    bit          typed;
    alloc_word_t res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic func = FN_ALLOC;
  logic [47:0] request_size = '0;
  logic [20:0] alignment = 21'd16;
  logic [46:0] block_address = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [46:0] address;
  logic [5:0] size_class;
  logic [18:0] block_size;
  logic [1:0] status;
  logic from_free_list;
  logic chunk_mapped;

  longint unsigned cursor_of[LIVE_CLASSES];
  longint unsigned chunks_of[LIVE_CLASSES];
  longint unsigned stack_of[LIVE_CLASSES][FREE_DEPTH];
  int depth_of[LIVE_CLASSES];

  alloc_word_t pending[$];
  logic [46:0] live_blocks[$];
  dir_row_t dir_rows[NDIR];
  int errors = 0;
  int accepted = 0;
  int quiet_cycles = 0;
  bit calm = 1'b0;

  size_class_block_allocator_top dut (.*);

  always #5 clk = ~clk;

  function automatic longint unsigned class_bytes(int c);
    longint unsigned base;
    if (c < 16) return longint'(c + 1) * 16;
    base = 64'd1 << (8 + (c - 16) / 4);
    return base + (base / 4) * longint'((c - 16) % 4 + 1);
  endfunction

  function automatic int class_for_bytes(longint unsigned n);
    int e;
    longint unsigned base, q;
    if (n <= 256) return (n == 0) ? 0 : int'((n + 15) / 16 - 1);
    e = 0;
    while (e < 63 && ((n - 1) >> (e + 1)) != 0) e++;
    base = 64'd1 << e;
    q = base / 4;
    return 16 + (e - 8) * 4 + int'((n - base + q - 1) / q - 1);
  endfunction

  function automatic longint unsigned seg_base(int c);
    return longint'(REGION_START) + (longint'(c) << SEGMENT_BITS);
  endfunction

  function automatic alloc_word_t serve_request(logic f, logic [47:0] sz, logic [20:0] al,
                                                logic [46:0] ad);
    alloc_word_t r;
    longint unsigned n, a, off, top, bytes;
    int c;
    r = '{default: '0};
    if (f == FN_ALLOC) begin
      n = sz;
      a = (al <= 16) ? 16 : al;
      if (n > SMALL_MAX || a > SMALL_MAX) begin
        r.st = ST_LARGE;
        return r;
      end
      c = class_for_bytes(n < a ? a : n);
      if (a != 16)
        while (c < LIVE_CLASSES && class_bytes(c) % a != 0) c++;
      if (c >= LIVE_CLASSES) begin
        r.st = ST_LARGE;
        return r;
      end
      bytes = class_bytes(c);
      r.cls = 6'(c);
      r.bsize = 19'(bytes);
      if (depth_of[c] > 0) begin
        depth_of[c]--;
        r.addr = 47'(seg_base(c) + stack_of[c][depth_of[c]]);
        r.reused = 1'b1;
        return r;
      end
      off = cursor_of[c];
      top = chunks_of[c] * CHUNK_BYTES;
      if (off + bytes > top) begin
        if (top + CHUNK_BYTES > (64'd1 << SEGMENT_BITS)) begin
          r.st = ST_EXHAUST;
          return r;
        end
        chunks_of[c]++;
        r.mapped = 1'b1;
      end
      cursor_of[c] = off + bytes;
      r.addr = 47'(seg_base(c) + off);
    end else begin
      if (ad < REGION_START || ad >= REGION_END) begin
        r.st = ST_LARGE;
        return r;
      end
      c = int'((longint'(ad) - longint'(REGION_START)) >> SEGMENT_BITS);
      r.cls = 6'(c);
      r.bsize = 19'(class_bytes(c));
      if (depth_of[c] >= FREE_DEPTH) begin
        r.st = ST_FULL;
        return r;
      end
      stack_of[c][depth_of[c]] = (longint'(ad) - longint'(REGION_START)) & SEG_MASK;
      depth_of[c]++;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    errors++;
  endtask

  // stall the result side
  always @(posedge clk) begin
    out_stall <= (!calm && $urandom_range(99) < 30);
  end

  always @(posedge clk) begin
    alloc_word_t e, p;
    if (!rst && in_valid && !in_stall) begin
      p = serve_request(func, request_size, alignment, block_address);
      if (accepted < NDIR && dir_rows[accepted].typed) p = dir_rows[accepted].res;
      if (func == FN_ALLOC && p.st == ST_OK) live_blocks.push_back(p.addr);
      pending.push_back(p);
      accepted++;
    end
    if (!rst && out_valid && !out_stall) begin
      if (pending.size() == 0) begin
        report_mismatch("unexpected word", address, 0);
      end else begin
        e = pending.pop_front();
        if (address !== e.addr) report_mismatch("address", address, e.addr);
        if (size_class !== e.cls) report_mismatch("size_class", size_class, e.cls);
        if (block_size !== e.bsize) report_mismatch("block_size", block_size, e.bsize);
        if (status !== e.st) report_mismatch("status", status, e.st);
        if (from_free_list !== e.reused)
          report_mismatch("from_free_list", from_free_list, e.reused);
        if (chunk_mapped !== e.mapped) report_mismatch("chunk_mapped", chunk_mapped, e.mapped);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG) begin
      $display("tb failed");
      $finish;
    end
  end

  task automatic send_word(logic f, logic [47:0] sz, logic [20:0] al, logic [46:0] ad);
    while (!calm && $urandom_range(99) < 30) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= f;
    request_size <= sz;
    alignment <= al;
    block_address <= ad;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic logic [46:0] region_addr(int c);
    return 47'(seg_base(c) + ({$urandom, $urandom} & SEG_MASK));
  endfunction

  function automatic logic [20:0] pick_alignment();
    int r;
    r = $urandom_range(99);
    if (r < 70) return 21'($urandom_range(16));
    if (r < 94) return 21'(1) << $urandom_range(5, 18);
    if (r < 97) return 21'($urandom);
    return 21'($urandom_range(3, 12) * 16);
  endfunction

  initial begin
    logic [47:0] sz;
    logic [46:0] ad;
    int r, idx;
    bit rel_heavy;
    foreach (cursor_of[c]) begin
      cursor_of[c] = 0;
      chunks_of[c] = 0;
      depth_of[c] = 0;
    end
    dir_rows[0] = '{FN_ALLOC, 48'd0, 21'd0, 47'd0, 1,
                    '{47'(REGION_START), 6'd0, 19'd16, ST_OK, 1'b0, 1'b1}};
    dir_rows[1] = '{FN_ALLOC, 48'd262144, 21'd1, 47'h7FFF_FFFF_FFFF, 1,
                    '{47'(seg_base(55)), 6'd55, 19'd262144, ST_OK, 1'b0, 1'b1}};
    dir_rows[2] = '{FN_ALLOC, 48'd262145, 21'd16, 47'd0, 1, '{0, 0, 0, ST_LARGE, 0, 0}};
    dir_rows[3] = '{FN_ALLOC, 48'd16, 21'd524288, 47'd0, 1, '{0, 0, 0, ST_LARGE, 0, 0}};
    dir_rows[4] = '{FN_ALLOC, 48'hFFFF_FFFF_FFFF, 21'h1F_FFFF, 47'd0, 1,
                    '{0, 0, 0, ST_LARGE, 0, 0}};
    dir_rows[5] = '{FN_RELEASE, 48'd0, 21'd0, 47'd0, 1, '{0, 0, 0, ST_LARGE, 0, 0}};
    dir_rows[6] = '{FN_RELEASE, 48'hFFFF_FFFF_FFFF, 21'h1F_FFFF, 47'h7FFF_FFFF_FFFF, 1,
                    '{0, 0, 0, ST_LARGE, 0, 0}};
    dir_rows[7] = '{FN_RELEASE, 48'd0, 21'd0, 47'(REGION_START), 1,
                    '{0, 6'd0, 19'd16, ST_OK, 0, 0}};
    dir_rows[8] = '{FN_ALLOC, 48'd1, 21'd16, 47'd0, 1,
                    '{47'(REGION_START), 6'd0, 19'd16, ST_OK, 1'b1, 1'b0}};
    dir_rows[9] = '{FN_ALLOC, 48'd300, 21'd64, 47'd0, 0, '{default: '0}};
    dir_rows[10] = '{FN_ALLOC, 48'd100, 21'd17, 47'd0, 0, '{default: '0}};
    dir_rows[11] = '{FN_ALLOC, 48'd48, 21'd48, 47'd0, 0, '{default: '0}};
    dir_rows[12] = '{FN_RELEASE, 48'd0, 21'd0, 47'(REGION_END - 1), 0, '{default: '0}};
    dir_rows[13] = '{FN_ALLOC, 48'd257, 21'd8, 47'd0, 0, '{default: '0}};
    dir_rows[14] = '{FN_ALLOC, 48'd4096, 21'd4096, 47'd0, 0, '{default: '0}};
    dir_rows[15] = '{FN_RELEASE, 48'd0, 21'd0, 47'(REGION_START - 1), 1,
                     '{0, 0, 0, ST_LARGE, 0, 0}};
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    foreach (dir_rows[i])
      send_word(dir_rows[i].f, dir_rows[i].sz, dir_rows[i].al, dir_rows[i].ad);
    for (int i = 0; i < NRAND; i++) begin
      calm = (i >= 300 && i < 420);
      rel_heavy = (i >= 420);
      r = $urandom_range(99);
      if (r < (rel_heavy ? 35 : 55)) begin
        r = $urandom_range(99);
        if (r < 75) sz = 48'($urandom_range(512));
        else if (r < 95) sz = 48'($urandom_range(262144));
        else sz = {16'($urandom), 32'($urandom)};
        send_word(FN_ALLOC, sz, pick_alignment(), {15'($urandom), 32'($urandom)});
      end else begin
        r = $urandom_range(99);
        if (r < 40 && live_blocks.size() > 0) begin
          idx = $urandom_range(live_blocks.size() - 1);
          ad = live_blocks[idx];
          live_blocks.delete(idx);
        end else if (r < 90) begin
          ad = region_addr(rel_heavy ? $urandom_range(1) : $urandom_range(LIVE_CLASSES - 1));
        end else begin
          ad = {15'($urandom), 32'($urandom)};
        end
        send_word(FN_RELEASE, {16'($urandom), 32'($urandom)}, 21'($urandom), ad);
      end
    end
    in_valid <= 1'b0;
    calm = 1'b0;
    while (pending.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end
endmodule
